@@ design/spce_pkg.sv @@
// Package for the sparse parity-check encoder: field widths, register and
// operation codes, parameter defaults and the sequencer state type.
// Depends on nothing; every other design file refers to it by scoped names.
package spce_pkg;

    // Defaults for the top-level storage parameters.
    localparam int MAX_INFO_BITS_DEF   = 4096;
    localparam int MAX_PARITY_BITS_DEF = 1024;
    localparam int MAX_ROW_WEIGHT_DEF  = 32;

    // Result framing.
    localparam int MAX_RESULTS = 16;
    localparam int WORD_BITS   = 64;

    // Field widths.
    localparam int INFO_LEN_W   = 13;
    localparam int PARITY_LEN_W = 11;
    localparam int ROW_W        = 10;
    localparam int SLOT_W       = 5;
    localparam int COL_W        = 13;
    localparam int CNT_W        = 6;
    localparam int WIDX_W       = 4;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [INFO_LEN_W-1:0]   INFO_LENGTH_RESET   = 13'd1024;
    localparam logic [PARITY_LEN_W-1:0] PARITY_LENGTH_RESET = 11'd512;

    // Register select, taken from the word address bit of paddr.
    localparam logic REG_INFO_LENGTH   = 1'b0;
    localparam logic REG_PARITY_LENGTH = 1'b1;

    // Input operations.
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_INFO = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_LEN_ERR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_SETUP,
        S_WALK,
        S_EMIT,
        S_ERR
    } t_state;

endpackage

@@ design/spce_in_if.sv @@
// Input channel of the sparse parity-check encoder: valid/ready and the
// fields of one input beat. Depends on spce_pkg for the field widths.
interface spce_in_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [spce_pkg::ROW_W-1:0]       row_index;
    logic [spce_pkg::SLOT_W-1:0]      edge_slot;
    logic [spce_pkg::COL_W-1:0]       edge_column;
    logic [spce_pkg::CNT_W-1:0]       edge_count;
    logic                             info_bit;
    logic                             last_bit;

    modport source (
        output valid, operation, row_index, edge_slot, edge_column, edge_count,
               info_bit, last_bit,
        input  ready
    );

    modport sink (
        input  valid, operation, row_index, edge_slot, edge_column, edge_count,
               info_bit, last_bit,
        output ready
    );
endinterface

@@ design/spce_out_if.sv @@
// Result channel of the sparse parity-check encoder: valid/ready and the
// fields of one result beat. Depends on spce_pkg for the field widths.
interface spce_out_if;
    logic                             valid;
    logic                             ready;
    logic [spce_pkg::WORD_BITS-1:0]   parity_word;
    logic [spce_pkg::WIDX_W-1:0]      word_index;
    logic                             status;
    logic                             last_word;

    modport source (
        output valid, parity_word, word_index, status, last_word,
        input  ready
    );

    modport sink (
        input  valid, parity_word, word_index, status, last_word,
        output ready
    );
endinterface

@@ design/sparse_parity_check_encoder.sv @@
// Top level of the sparse parity-check encoder: edge table, codeword store,
// row sequencer, result register and configuration port.
// Depends on spce_pkg, spce_in_if and spce_out_if.
//
// Usage. The input channel carries two kinds of beats. An edge beat
// (operation 0) writes one edge, the column index of one entry in a row
// of the parity-check matrix, into the edge table, together with the
// row's edge count. An information beat (operation 1) stores one bit of
// the codeword. Edge and non-final information beats are accepted
// whenever the block is idle and give no result. On the information beat
// flagged last, the block checks the received count against info_length.
// On a mismatch, or with a length outside the supported range, it sends
// one error result. Otherwise a sequencer walks the rows in order: one
// memory read pipeline (edge table, then codeword store) feeds a single
// XOR accumulator. Each completed group of 64 parity bits, and the last
// partial group, is handed to the result register in an emit step.
// The input is not ready for the whole walk, and the receiver can stretch
// it: the sequencer holds a finished word until the result register is
// free, and the result register holds a beat until it is taken. Reset is
// synchronous; the tables need no clearing because every entry read was
// written beforehand, and parity bits not yet computed in the current
// block are masked to zero. Configuration registers are written through
// the APB-style port; the user must write them only while the block is
// idle, which the block itself does not enforce.
module sparse_parity_check_encoder #(
    parameter int MAX_INFO_BITS   = spce_pkg::MAX_INFO_BITS_DEF,
    parameter int MAX_PARITY_BITS = spce_pkg::MAX_PARITY_BITS_DEF,
    parameter int MAX_ROW_WEIGHT  = spce_pkg::MAX_ROW_WEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spce_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [spce_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [spce_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,

    spce_in_if.sink                           i_in,
    spce_out_if.source                        o_out
);

    localparam int EDGE_DEPTH = MAX_PARITY_BITS * MAX_ROW_WEIGHT;
    localparam int CODE_DEPTH = MAX_INFO_BITS + MAX_PARITY_BITS;
    localparam int EA_W       = $clog2(EDGE_DEPTH);
    localparam int RA_W       = $clog2(MAX_PARITY_BITS);
    localparam int CA_W       = $clog2(CODE_DEPTH);
    localparam int E_W        = $clog2(MAX_ROW_WEIGHT);
    localparam int BR_W       = $clog2(MAX_INFO_BITS + 2);
    localparam int WB_W       = $clog2(spce_pkg::WORD_BITS);
    localparam int COL_W      = spce_pkg::COL_W;
    localparam int CNT_W      = spce_pkg::CNT_W;
    localparam int WORD_BITS  = spce_pkg::WORD_BITS;
    localparam int WIDX_W     = spce_pkg::WIDX_W;

    // Configuration registers.
    logic [spce_pkg::INFO_LEN_W-1:0]   r_info_len;
    logic [spce_pkg::PARITY_LEN_W-1:0] r_parity_len;

    // Memories.
    logic [COL_W-1:0] r_edge_mem [EDGE_DEPTH];
    logic [CNT_W-1:0] r_cnt_mem  [MAX_PARITY_BITS];
    logic             r_cw_mem   [CODE_DEPTH];

    // Sequencer state.
    spce_pkg::t_state     r_state, n_state;
    logic [BR_W-1:0]      r_bits, n_bits;
    logic [RA_W-1:0]      r_row, n_row;
    logic [EA_W-1:0]      r_base, n_base;
    logic [E_W-1:0]       r_e, n_e;
    logic [E_W-1:0]       r_nedge, n_nedge;
    logic                 r_acc, n_acc;
    logic [WORD_BITS-1:0] r_word, n_word;

    // Read pipeline.
    logic                 r_p1;
    logic                 r_p2;
    logic                 r_mask;
    logic [COL_W-1:0]     r_edge_q;
    logic [CNT_W-1:0]     r_cnt_q;
    logic                 r_cw_q;

    // Result register.
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_word;
    logic [WIDX_W-1:0]    r_out_widx;
    logic                 r_out_status;
    logic                 r_out_last;

    // Combinational control.
    logic                 in_fire;
    logic                 info_fire;
    logic                 edge_ok;
    logic                 edge_wr;
    logic [EA_W-1:0]      edge_wr_addr;
    logic [RA_W-1:0]      cnt_wr_addr;
    logic [BR_W-1:0]      bits_next;
    logic                 len_err;
    logic                 issue;
    logic [EA_W-1:0]      edge_rd_addr;
    logic                 col_ok;
    logic [CA_W-1:0]      cw_rd_addr;
    logic                 walk_done;
    logic                 row_last;
    logic                 group_end;
    logic [31:0]          cnt_clamp;
    logic                 out_free;
    logic                 out_load;
    logic [WORD_BITS-1:0] ld_word;
    logic [WIDX_W-1:0]    ld_widx;
    logic                 ld_status;
    logic                 ld_last;
    logic                 cw_wr_en;
    logic [CA_W-1:0]      cw_wr_addr;
    logic                 cw_wr_data;
    logic                 cfg_wr;

    // ------------------------------------------------------------------
    // Configuration port. A write lands on the access cycle; reads return
    // the register picked by the word address bit.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            spce_pkg::REG_INFO_LENGTH:   prdata = 32'(r_info_len);
            spce_pkg::REG_PARITY_LENGTH: prdata = 32'(r_parity_len);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_info_len   <= spce_pkg::INFO_LENGTH_RESET;
            r_parity_len <= spce_pkg::PARITY_LENGTH_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                spce_pkg::REG_INFO_LENGTH:
                    r_info_len <= pwdata[spce_pkg::INFO_LEN_W-1:0];
                spce_pkg::REG_PARITY_LENGTH:
                    r_parity_len <= pwdata[spce_pkg::PARITY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input decode. Edges outside the table dimensions are dropped.
    // ------------------------------------------------------------------
    assign in_fire   = i_in.valid && i_in.ready;
    assign info_fire = in_fire && (i_in.operation == spce_pkg::OP_INFO);
    assign edge_ok   = (32'(i_in.row_index) < 32'(MAX_PARITY_BITS)) &&
                       (32'(i_in.edge_slot) < 32'(MAX_ROW_WEIGHT));
    assign edge_wr   = in_fire && (i_in.operation == spce_pkg::OP_EDGE) && edge_ok;
    assign edge_wr_addr = EA_W'(32'(i_in.row_index) * 32'(MAX_ROW_WEIGHT)
                                + 32'(i_in.edge_slot));
    assign cnt_wr_addr  = RA_W'(i_in.row_index);

    // The received count saturates one past the maximum so that an
    // overlong block can never match.
    assign bits_next = (32'(r_bits) <= 32'(MAX_INFO_BITS)) ? r_bits + 1'b1 : r_bits;

    assign len_err = (32'(bits_next) != 32'(r_info_len)) ||
                     (r_info_len == '0) ||
                     (32'(r_info_len) > 32'(MAX_INFO_BITS)) ||
                     (r_parity_len == '0) ||
                     (32'(r_parity_len) > 32'(MAX_PARITY_BITS)) ||
                     (32'(r_parity_len) > 32'(WORD_BITS * spce_pkg::MAX_RESULTS));

    // ------------------------------------------------------------------
    // Edge walk. Stage 0 reads the edge table, stage 1 checks the column
    // and reads the codeword store, stage 2 folds the bit into the XOR.
    // A column at or past info_length + row is a parity bit that is not
    // computed yet (or lies outside the codeword) and counts as zero.
    // ------------------------------------------------------------------
    assign issue        = (r_state == spce_pkg::S_WALK) && (r_e != r_nedge);
    assign edge_rd_addr = r_base + EA_W'(r_e);
    assign col_ok       = 32'(r_edge_q) < (32'(r_info_len) + 32'(r_row));
    assign cw_rd_addr   = CA_W'(32'(r_edge_q));
    assign walk_done    = (r_state == spce_pkg::S_WALK) && (r_e == r_nedge) &&
                          !r_p1 && !r_p2;
    assign row_last     = 32'(r_row) == (32'(r_parity_len) - 32'd1);
    assign group_end    = (r_row[WB_W-1:0] == {WB_W{1'b1}}) || row_last;

    // The last stored edge of a row is the parity bit itself, so a row reads
    // all of its stored edges but the last; counts above the row width are clamped.
    assign cnt_clamp = (32'(r_cnt_q) > 32'(MAX_ROW_WEIGHT)) ? 32'(MAX_ROW_WEIGHT)
                                                             : 32'(r_cnt_q);

    // Codeword store write port: information bits while idle, parity bits
    // at the end of each row walk.
    assign cw_wr_en   = (info_fire && (32'(r_bits) < 32'(MAX_INFO_BITS))) || walk_done;
    assign cw_wr_addr = walk_done ? CA_W'(32'(r_info_len) + 32'(r_row)) : CA_W'(r_bits);
    assign cw_wr_data = walk_done ? r_acc : i_in.info_bit;

    assign out_free = !r_out_valid || o_out.ready;

    // ------------------------------------------------------------------
    // Sequencer: next state and strobes.
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_bits     = r_bits;
        n_row      = r_row;
        n_base     = r_base;
        n_e        = r_e;
        n_nedge    = r_nedge;
        n_acc      = r_acc;
        n_word     = r_word;
        i_in.ready = 1'b0;
        out_load   = 1'b0;
        ld_word    = '0;
        ld_widx    = '0;
        ld_status  = spce_pkg::STATUS_OK;
        ld_last    = 1'b0;

        unique case (r_state)
            spce_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (info_fire) begin
                    n_bits = bits_next;
                    if (i_in.last_bit) begin
                        n_bits = '0;
                        n_row  = '0;
                        n_base = '0;
                        n_word = '0;
                        n_state = len_err ? spce_pkg::S_ERR : spce_pkg::S_ROW;
                    end
                end
            end
            spce_pkg::S_ROW: begin
                // Row edge count is being read.
                n_state = spce_pkg::S_SETUP;
            end
            spce_pkg::S_SETUP: begin
                n_nedge = (cnt_clamp < 32'd2) ? '0 : E_W'(cnt_clamp - 32'd1);
                n_e     = '0;
                n_acc   = 1'b0;
                n_state = spce_pkg::S_WALK;
            end
            spce_pkg::S_WALK: begin
                if (issue) begin
                    n_e = r_e + 1'b1;
                end
                if (r_p2) begin
                    n_acc = r_acc ^ (r_cw_q & r_mask);
                end
                if (walk_done) begin
                    n_word[r_row[WB_W-1:0]] = r_acc;
                    if (group_end) begin
                        n_state = spce_pkg::S_EMIT;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_base  = r_base + EA_W'(MAX_ROW_WEIGHT);
                        n_state = spce_pkg::S_ROW;
                    end
                end
            end
            spce_pkg::S_EMIT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    ld_word   = r_word;
                    ld_widx   = WIDX_W'(32'(r_row) >> WB_W);
                    ld_status = spce_pkg::STATUS_OK;
                    ld_last   = row_last;
                    n_word    = '0;
                    if (row_last) begin
                        n_state = spce_pkg::S_IDLE;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_base  = r_base + EA_W'(MAX_ROW_WEIGHT);
                        n_state = spce_pkg::S_ROW;
                    end
                end
            end
            spce_pkg::S_ERR: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    ld_word   = '0;
                    ld_widx   = '0;
                    ld_status = spce_pkg::STATUS_LEN_ERR;
                    ld_last   = 1'b1;
                    n_state   = spce_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spce_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spce_pkg::S_IDLE;
            r_bits  <= '0;
            r_p1    <= 1'b0;
            r_p2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bits  <= n_bits;
            r_p1    <= issue;
            r_p2    <= r_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_base  <= n_base;
        r_e     <= n_e;
        r_nedge <= n_nedge;
        r_acc   <= n_acc;
        r_word  <= n_word;
        r_mask  <= col_ok;
    end

    // ------------------------------------------------------------------
    // Memories, one write and one registered read port each.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (edge_wr) begin
            r_edge_mem[edge_wr_addr] <= i_in.edge_column;
        end
        if (issue) begin
            r_edge_q <= r_edge_mem[edge_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (edge_wr) begin
            r_cnt_mem[cnt_wr_addr] <= i_in.edge_count;
        end
        if (r_state == spce_pkg::S_ROW) begin
            r_cnt_q <= r_cnt_mem[r_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cw_wr_en) begin
            r_cw_mem[cw_wr_addr] <= cw_wr_data;
        end
        if (r_p1) begin
            r_cw_q <= r_cw_mem[cw_rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Result register: holds one beat until the receiver takes it.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word   <= ld_word;
            r_out_widx   <= ld_widx;
            r_out_status <= ld_status;
            r_out_last   <= ld_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.parity_word = r_out_word;
    assign o_out.word_index  = r_out_widx;
    assign o_out.status      = r_out_status;
    assign o_out.last_word   = r_out_last;

endmodule
